### src/particle_swarm_update_engine_unit_assert.svh
// Assertion macros for the checker file of the swarm update engine.
`ifndef PARTICLE_SWARM_UPDATE_ENGINE_UNIT_ASSERT_SVH
`define PARTICLE_SWARM_UPDATE_ENGINE_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define PSU_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define PSU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

### src/psu_pkg.sv
// Package of the swarm update engine: types, command codes and constants.
`default_nettype none
package psu_pkg;
  localparam int PARTICLES = 64;
  localparam int DIMS = 16;
  localparam int PW = $clog2(PARTICLES);
  localparam int DW = $clog2(DIMS);
  localparam int AW = PW + DW;
  localparam logic signed [31:0] COST_MAX = 32'sh7FFF_FFFF;
  localparam logic [23:0] ONE_FIFTH_Q24 = 24'd3355443;

  typedef enum logic [2:0] {
    CMD_BOUNDS = 3'd0, CMD_LOAD = 3'd1, CMD_MOVE = 3'd2, CMD_REPORT = 3'd3, CMD_READ = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    REG_DIMS = 2'd0, REG_CGAIN = 2'd1, REG_SGAIN = 2'd2
  } reg_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_MUL, ST_SUM, ST_CLAMP, ST_POS, ST_COPY_RD, ST_COPY_WR,
    ST_GLOB, ST_GCOPY_RD, ST_GCOPY_WR, ST_OUT
  } state_t;

  // Maps the dimension register to the number of elements in use.
  function automatic logic [DW:0] used_dims(input logic [4:0] n);
    logic [DW:0] r;
    if (n == 5'd0) r = (DW+1)'(1);
    else if (32'(n) > DIMS) r = (DW+1)'(DIMS);
    else r = (DW+1)'(n);
    return r;
  endfunction
endpackage
`default_nettype wire

### src/particle_swarm_update_engine_unit.sv
// Top level of the swarm update engine: stores, sequencer and arithmetic.
// Channel  | signals                         | item
// s_axis   | tvalid tready tdata             | one command
// m_axis   | tvalid tready tdata tuser       | one result
// cfg      | cfg_valid cfg_ready idx data    | one register write
// Bounds, load and read go from the memory read to the output; a move passes the
// memory read, two product stages, the velocity clamp and the position clamp. A
// fitness report copies each element with a read and then a write, set by the single memory port.
// Reset is synchronous; stores are not cleared. A stalled result holds the
// block in its output state until taken.
`default_nettype none
module particle_swarm_update_engine_unit (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // cmd[2:0] particle[8:3] dim[12:9] value_a[44:13] value_b[76:45] inertia[92:77]
  // rand_cognitive[108:93] rand_social[124:109] fitness[156:125], zeros above
  input  wire logic [159:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // value[31:0] best_fitness[63:32]
  output logic [63:0]       m_axis_tdata,
  // personal_improved[0] global_improved[1] last_dim[2]
  output logic [2:0]        m_axis_tuser,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [15:0]  cfg_data
);
  import psu_pkg::*;

  state_t state, state_next;
  logic [4:0] dims_in_use;
  logic [15:0] cgain, sgain;
  logic [2:0] cmd;
  logic [PW-1:0] part;
  logic [DW-1:0] dim, idx;
  logic signed [31:0] va, vb, fit;
  logic [15:0] w, r1, r2;
  logic signed [31:0] x, v, pb, gb, lo, hi, lim;
  logic signed [31:0] out_value, gcost;
  logic pimp, gimp;
  logic signed [63:0] m_w, m_c, m_s;
  logic signed [33:0] dp, dg;
  logic [17:0] cg, sg;
  logic signed [63:0] vsum;
  logic signed [63:0] vclip;
  logic signed [31:0] vnew;
  logic signed [32:0] xsum;
  logic signed [31:0] xnew;

  // Per-element stores, one port each.
  logic signed [31:0] pos_mem [PARTICLES*DIMS];
  logic signed [31:0] vel_mem [PARTICLES*DIMS];
  logic signed [31:0] pb_mem  [PARTICLES*DIMS];
  logic signed [31:0] pbc_mem [PARTICLES];
  logic signed [31:0] gb_mem [DIMS];
  logic signed [31:0] lo_mem [DIMS];
  logic signed [31:0] hi_mem [DIMS];
  logic signed [31:0] lim_mem [DIMS];
  logic signed [31:0] pos_rd, vel_rd, pb_rd, pbc_rd, gb_rd, lo_rd, hi_rd, lim_rd;

  logic [AW-1:0] ea, ca;
  logic [PW-1:0] rd_part;
  logic [DW-1:0] rd_dim;
  logic [DW:0] n_used;
  logic signed [31:0] pbc_cur;
  logic signed [57:0] span_prod;
  logic signed [32:0] span;

  assign n_used = used_dims(dims_in_use);
  assign ea = {part, dim};
  assign ca = {part, idx};
  assign cfg_ready = (state == ST_IDLE);
  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = (state == ST_OUT);
  assign m_axis_tdata = {gcost, out_value};
  assign m_axis_tuser = {((DW+1)'(dim) + (DW+1)'(1) == n_used), gimp, pimp};

  // While idle the stores are addressed by the incoming item, so its data is ready in ST_READ.
  assign rd_part = (state == ST_IDLE) ? s_axis_tdata[8:3] : part;
  assign rd_dim = (state == ST_IDLE) ? s_axis_tdata[12:9] : dim;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      dims_in_use <= 5'd16;
      cgain <= 16'd13107;
      sgain <= 16'd24412;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_t'(cfg_index))
        REG_DIMS: dims_in_use <= cfg_data[4:0];
        REG_CGAIN: cgain <= cfg_data;
        REG_SGAIN: sgain <= cfg_data;
        default: ;
      endcase
    end
  end

  // Memory reads, registered; addresses follow the sequencer.
  always_ff @(posedge clk) begin
    pos_rd <= pos_mem[(state == ST_COPY_RD) ? ca : {rd_part, rd_dim}];
    vel_rd <= vel_mem[{rd_part, rd_dim}];
    pb_rd  <= pb_mem[(state == ST_GCOPY_RD) ? ca : {rd_part, rd_dim}];
    pbc_rd <= pbc_mem[rd_part];
    gb_rd  <= gb_mem[rd_dim];
    lo_rd  <= lo_mem[rd_dim];
    hi_rd  <= hi_mem[rd_dim];
    lim_rd <= lim_mem[rd_dim];
  end

  // Memory writes.
  always_ff @(posedge clk) begin
    if (state == ST_READ && cmd == CMD_BOUNDS) begin
      lo_mem[dim] <= va;
      hi_mem[dim] <= vb;
      lim_mem[dim] <= span_prod[55:24];
    end
    if (state == ST_READ && cmd == CMD_LOAD) begin
      pos_mem[ea] <= va;
      vel_mem[ea] <= vb;
      pb_mem[ea] <= va;
      pbc_mem[part] <= COST_MAX;
    end
    if (state == ST_POS) begin
      vel_mem[ea] <= vnew;
      pos_mem[ea] <= xnew;
    end
    if (state == ST_READ && cmd == CMD_REPORT && fit <= pbc_rd) pbc_mem[part] <= fit;
    if (state == ST_COPY_WR) pb_mem[ca] <= pos_rd;
    if (state == ST_GCOPY_WR) gb_mem[idx] <= pb_rd;
  end

  assign span = 33'(vb) - 33'(va);
  assign span_prod = 58'(span) * $signed({1'b0, ONE_FIFTH_Q24}) + 58'sd8388608;
  assign pbc_cur = pimp ? fit : pbc_rd;

  // Velocity sum rounded to Q16.16, then clamped to the speed limit; the upper limit wins.
  assign vsum = m_w + m_c + m_s + 64'sd32768;
  always_comb begin
    vclip = vsum >>> 16;
    if (vclip < -64'(lim)) vclip = -64'(lim);
    if (vclip > 64'(lim)) vclip = 64'(lim);
  end

  // Position step clamped to the bounds; the upper bound wins when they are reversed.
  assign xsum = 33'(x) + 33'(vnew);
  always_comb begin
    if (xsum > 33'(hi)) xnew = hi;
    else if (xsum < 33'(lo)) xnew = (lo > hi) ? hi : lo;
    else xnew = 32'(xsum);
  end

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (s_axis_tvalid) state_next = ST_READ;
      ST_READ: begin
        case (cmd)
          CMD_MOVE: state_next = ST_MUL;
          CMD_REPORT: state_next = (fit <= pbc_rd) ? ST_COPY_RD : ST_GLOB;
          default: state_next = ST_OUT;
        endcase
      end
      ST_MUL: state_next = ST_SUM;
      ST_SUM: state_next = ST_CLAMP;
      ST_CLAMP: state_next = ST_POS;
      ST_POS: state_next = ST_OUT;
      ST_COPY_RD: state_next = ST_COPY_WR;
      ST_COPY_WR: state_next = ((DW+1)'(idx) + 1'b1 == n_used) ? ST_GLOB : ST_COPY_RD;
      ST_GLOB: state_next = (pbc_cur < gcost) ? ST_GCOPY_RD : ST_OUT;
      ST_GCOPY_RD: state_next = ST_GCOPY_WR;
      ST_GCOPY_WR: state_next = ((DW+1)'(idx) + 1'b1 == n_used) ? ST_OUT : ST_GCOPY_RD;
      ST_OUT: if (m_axis_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      gcost <= COST_MAX;
      pimp <= 1'b0;
      gimp <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: if (s_axis_tvalid) begin
          cmd <= s_axis_tdata[2:0];
          part <= s_axis_tdata[8:3];
          dim <= s_axis_tdata[12:9];
          va <= s_axis_tdata[44:13];
          vb <= s_axis_tdata[76:45];
          w <= s_axis_tdata[92:77];
          r1 <= s_axis_tdata[108:93];
          r2 <= s_axis_tdata[124:109];
          fit <= s_axis_tdata[156:125];
          pimp <= 1'b0;
          gimp <= 1'b0;
          idx <= '0;
        end
        ST_READ: begin
          x <= pos_rd; v <= vel_rd; pb <= pb_rd; gb <= gb_rd;
          lo <= lo_rd; hi <= hi_rd; lim <= lim_rd;
          cg <= 18'((32'(cgain) * 32'(r1)) >> 14);
          sg <= 18'((32'(sgain) * 32'(r2)) >> 14);
          case (cmd)
            CMD_BOUNDS: out_value <= span_prod[55:24];
            CMD_LOAD: out_value <= va;
            CMD_READ: out_value <= gb_rd;
            default: out_value <= '0;
          endcase
          if (cmd == CMD_REPORT && fit <= pbc_rd) pimp <= 1'b1;
        end
        ST_MUL: begin
          dp <= 34'(pb) - 34'(x);
          dg <= 34'(gb) - 34'(x);
          m_w <= 64'(v) * $signed({1'b0, w});
        end
        ST_SUM: begin
          m_c <= 64'(dp) * $signed({1'b0, cg});
          m_s <= 64'(dg) * $signed({1'b0, sg});
        end
        ST_CLAMP: vnew <= 32'(vclip);
        ST_POS: out_value <= xnew;
        ST_COPY_WR: idx <= idx + 1'b1;
        ST_GLOB: begin
          idx <= '0;
          if (pbc_cur < gcost) begin
            gcost <= pbc_cur;
            gimp <= 1'b1;
          end
        end
        ST_GCOPY_WR: idx <= idx + 1'b1;
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

### src/psu_checker.sv
// Port-level checker of the swarm update engine and its bind.
`default_nettype none
`include "particle_swarm_update_engine_unit_assert.svh"
module psu_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic s_axis_tvalid,
  input wire logic s_axis_tready,
  input wire logic m_axis_tvalid,
  input wire logic m_axis_tready,
  input wire logic [63:0] m_axis_tdata,
  input wire logic [2:0] m_axis_tuser,
  input wire logic cfg_ready
);
  // No new item is taken while a result waits.
  `PSU_ASSERT_IMPL(a_no_take_busy, m_axis_tvalid, !s_axis_tready, "input ready while result pending")
  // A taken item produces no result in the very next cycle.
  `PSU_ASSERT_NEXT(a_gap, s_axis_tvalid && s_axis_tready, !m_axis_tvalid, "result too early")
  // Configuration is only taken while idle.
  `PSU_ASSERT_IMPL(a_cfg_idle, cfg_ready, s_axis_tready, "config ready while busy")
  // A stalled result keeps its contents until taken.
  `PSU_ASSERT_IMPL(a_cost_mono, m_axis_tvalid && $past(m_axis_tvalid) && !$past(m_axis_tready),
                   $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")
endmodule
bind particle_swarm_update_engine_unit psu_checker u_psu_checker (.*);
`default_nettype wire
